### hdl/wtr_pkg.sv
// ----------------------------------------------------------------------------
// wtr_pkg: shared types and constants of the windowed tick rate meter
// Field widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package wtr_pkg;

	// result field widths
	localparam int AVG_W   = 40;
	localparam int RATE_W  = 48;
	localparam int COUNT_W = 5;

	// fixed point scaling of the results
	localparam int AVG_FRAC  = 8;
	localparam int RATE_FRAC = 16;

	// configuration registers
	localparam int WLEN_W     = 5;
	localparam int TB_W       = 30;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 30;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEBASE_HZ   = 2'd1;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd10;
	localparam logic [TB_W-1:0]   TB_RESET   = 30'd1000000;

	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_RING,
		ST_MUL,
		ST_DIV_AVG,
		ST_DIV_RATE,
		ST_OUT
	} st_t;

endpackage

### hdl/wtr_if.sv
// ----------------------------------------------------------------------------
// wtr_if: request channels of the windowed tick rate meter
// Tick channel (timestamp in) and result channel (averages out).
// ----------------------------------------------------------------------------
interface wtr_tick_if #(
	parameter int TIME_WIDTH = 32
);
	logic                  valid;
	logic                  ready;
	logic [TIME_WIDTH-1:0] timestamp;

	modport source (output valid, output timestamp, input ready);
	modport sink   (input valid, input timestamp, output ready);
endinterface

interface wtr_result_if;
	import wtr_pkg::*;

	logic               valid;
	logic               ready;
	logic               average_valid;
	logic [AVG_W-1:0]   average_interval;
	logic [RATE_W-1:0]  event_rate;
	logic [COUNT_W-1:0] interval_count;

	modport source (
		output valid, output average_valid, output average_interval,
		output event_rate, output interval_count, input ready
	);
	modport sink (
		input valid, input average_valid, input average_interval,
		input event_rate, input interval_count, output ready
	);
endinterface

### hdl/wtr_div.sv
// ----------------------------------------------------------------------------
// wtr_div: shared restoring divider
// One quotient bit per cycle, done pulses once.
// ----------------------------------------------------------------------------
module wtr_div #(
	parameter int DVD_W = 52,
	parameter int DVS_W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           ge;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && !busy_q)
		else $error("divider done without a running division");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && dvs_q != '0) |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");

endmodule

### hdl/windowed_tick_rate_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_tick_rate_meter_core: moving average interval and event rate
// Stores tick intervals in a window ring, keeps their running sum, and per
// tick reports mean interval (Q32.8) and events per second (Q32.16).
// ----------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------
//  tick     | in  | valid/ready  | timestamp
//  result   | out | valid/ready  | average_valid, average_interval,
//           |     |              | event_rate, interval_count
//  cfg      | in  | cfg_we only  | cfg_index, cfg_data (no back-pressure)
//
//  A tick passes the store state, the ring state once the window ring
//  turns over, the multiply state, the average and rate divisions on the
//  shared one-bit-per-cycle divider, and the output state. A zero window
//  sum skips the rate division, a tick with no stored interval skips both.
//  Reset clears the sequencer, the fill count, ring pointer and sum, and
//  loads the config registers with their reset values; the interval
//  memory is not cleared, no clearing pass. tick.ready is high only
//  while the sequencer is idle. A finished result sits in the output
//  register, so the next tick is taken while it waits.
// ----------------------------------------------------------------------------
module windowed_tick_rate_meter_core #(
	parameter int WINDOW_DEPTH = 16,
	parameter int TIME_WIDTH   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wtr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wtr_pkg::CFG_DATA_W-1:0] cfg_data,
	wtr_tick_if.sink                       tick,
	wtr_result_if.source                   result
);
	import wtr_pkg::*;

	// storage and arithmetic widths
	localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W   = TIME_WIDTH + IDX_W;
	localparam int MUL_W   = TB_W + CNT_W;
	localparam int LEN_W   = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int AVGN_W  = SUM_W + AVG_FRAC;
	localparam int RATEN_W = ((MUL_W + RATE_FRAC > SUM_W) ? MUL_W + RATE_FRAC : SUM_W) + 1;
	localparam int DVD_W   = (AVGN_W > RATEN_W) ? AVGN_W : RATEN_W;

	// config registers
	logic [WLEN_W-1:0] wlen_q;
	logic [TB_W-1:0]   tb_q;

	// window state
	logic                  seen_q;
	logic                  have_delta_q;
	logic [TIME_WIDTH-1:0] prev_q;
	logic [TIME_WIDTH-1:0] delta_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      ring_q;
	logic [SUM_W-1:0]      sum_q;

	// interval memory, undefined until written
	logic [TIME_WIDTH-1:0] mem [WINDOW_DEPTH];
	logic [TIME_WIDTH-1:0] rd_q;

	// intermediate results
	logic [MUL_W-1:0]  mul_q;
	logic [AVG_W-1:0]  avg_q;
	logic [RATE_W-1:0] rate_q;

	// output register
	logic               res_valid_q;
	logic               res_avg_valid_q;
	logic [AVG_W-1:0]   res_avg_q;
	logic [RATE_W-1:0]  res_rate_q;
	logic [COUNT_W-1:0] res_cnt_q;

	st_t state_q, state_d;

	// sequencer controls
	logic             tick_ready;
	logic             fill_wr;
	logic             ring_rd;
	logic             ring_wr;
	logic             mul_load;
	logic             res_clear;
	logic             div_start;
	logic             div_rate_sel;
	logic             avg_load;
	logic             rate_load;
	logic             rate_sat_load;
	logic             out_load;

	// derived window signals
	logic [LEN_W-1:0] wlen_ext;
	logic [LEN_W-1:0] eff_len;
	logic             fill_lt;
	logic [CNT_W-1:0] ring_ext;
	logic [CNT_W-1:0] slot;
	logic [CNT_W-1:0] slot_inc;
	logic [IDX_W-1:0] ring_next;
	logic             tick_acc;
	logic             out_free;

	// divider hookup
	logic [DVD_W-1:0] div_dividend;
	logic [SUM_W-1:0] div_divisor;
	logic             div_busy;
	logic             div_done;
	logic [DVD_W-1:0] div_quot;
	logic             rate_over;

	assign tick_acc = tick.valid && tick_ready;
	assign out_free = !res_valid_q || result.ready;

	// window length clamped to 1..WINDOW_DEPTH
	always_comb begin
		wlen_ext = LEN_W'(wlen_q);
		eff_len  = wlen_ext;
		if (wlen_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (wlen_ext > LEN_W'(WINDOW_DEPTH)) begin
			eff_len = LEN_W'(WINDOW_DEPTH);
		end
	end

	assign fill_lt = LEN_W'(fill_q) < eff_len;

	// ring slot: a pointer past the fill count (window shrunk) wraps to 0
	assign ring_ext  = CNT_W'(ring_q);
	assign slot      = (ring_ext >= fill_q) ? '0 : ring_ext;
	assign slot_inc  = slot + 1'b1;
	assign ring_next = (slot_inc >= fill_q) ? '0 : slot_inc[IDX_W-1:0];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
			tb_q   <= TB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH: wlen_q <= cfg_data[WLEN_W-1:0];
				CFG_TIMEBASE_HZ:   tb_q   <= cfg_data[TB_W-1:0];
				default:           ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (tick.valid) begin
					state_d = ST_STORE;
				end
			end
			ST_STORE: begin
				state_d = (have_delta_q && !fill_lt) ? ST_RING : ST_MUL;
			end
			ST_RING: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				state_d = (fill_q == '0) ? ST_OUT : ST_DIV_AVG;
			end
			ST_DIV_AVG: begin
				if (div_done) begin
					state_d = (sum_q == '0) ? ST_OUT : ST_DIV_RATE;
				end
			end
			ST_DIV_RATE: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controls
	always_comb begin
		tick_ready    = 1'b0;
		fill_wr       = 1'b0;
		ring_rd       = 1'b0;
		ring_wr       = 1'b0;
		mul_load      = 1'b0;
		res_clear     = 1'b0;
		div_start     = 1'b0;
		div_rate_sel  = 1'b0;
		avg_load      = 1'b0;
		rate_load     = 1'b0;
		rate_sat_load = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: tick_ready = 1'b1;
			ST_STORE: begin
				fill_wr = have_delta_q && fill_lt;
				ring_rd = have_delta_q && !fill_lt;
			end
			ST_RING: ring_wr = 1'b1;
			ST_MUL: begin
				mul_load  = 1'b1;
				res_clear = (fill_q == '0);
				div_start = (fill_q != '0);
			end
			ST_DIV_AVG: begin
				if (div_done) begin
					avg_load      = 1'b1;
					rate_sat_load = (sum_q == '0);
					div_start     = (sum_q != '0);
					div_rate_sel  = 1'b1;
				end
			end
			ST_DIV_RATE: rate_load = div_done;
			ST_OUT:      out_load  = out_free;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			have_delta_q <= 1'b0;
			prev_q       <= '0;
			fill_q       <= '0;
			ring_q       <= '0;
			sum_q        <= '0;
		end else begin
			if (tick_acc) begin
				// first tick after reset only records its time
				have_delta_q <= seen_q;
				seen_q       <= 1'b1;
				prev_q       <= tick.timestamp;
			end
			if (fill_wr) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + SUM_W'(delta_q);
			end
			if (ring_wr) begin
				// replace the oldest interval in the running sum
				sum_q  <= sum_q + SUM_W'(delta_q) - SUM_W'(rd_q);
				ring_q <= ring_next;
			end
		end
	end

	// interval wraps modulo 2^TIME_WIDTH by width
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			delta_q <= tick.timestamp - prev_q;
		end
	end

	// interval memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (fill_wr) begin
			mem[fill_q[IDX_W-1:0]] <= delta_q;
		end else if (ring_wr) begin
			mem[slot[IDX_W-1:0]] <= delta_q;
		end
		if (ring_rd) begin
			rd_q <= mem[slot[IDX_W-1:0]];
		end
	end

	// operand select for the shared divider
	always_comb begin
		if (div_rate_sel) begin
			// (timebase * count * 2^16 + sum/2) / sum
			div_dividend = (DVD_W'(mul_q) << RATE_FRAC) + DVD_W'(sum_q >> 1);
			div_divisor  = sum_q;
		end else begin
			// (sum * 2^8 + count/2) / count
			div_dividend = (DVD_W'(sum_q) << AVG_FRAC) + DVD_W'(fill_q >> 1);
			div_divisor  = SUM_W'(fill_q);
		end
	end

	wtr_div #(
		.DVD_W (DVD_W),
		.DVS_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign rate_over = div_quot > DVD_W'(RATE_MAX);

	// per-tick arithmetic results
	always_ff @(posedge clk) begin
		if (mul_load) begin
			mul_q <= MUL_W'(tb_q) * MUL_W'(fill_q);
		end
		if (res_clear) begin
			avg_q  <= '0;
			rate_q <= '0;
		end
		if (avg_load) begin
			avg_q <= div_quot[AVG_W-1:0];
		end
		if (rate_sat_load) begin
			rate_q <= RATE_MAX;
		end
		if (rate_load) begin
			rate_q <= rate_over ? RATE_MAX : RATE_W'(div_quot);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_avg_valid_q <= (fill_q != '0);
			res_avg_q       <= avg_q;
			res_rate_q      <= rate_q;
			res_cnt_q       <= COUNT_W'(fill_q);
		end
	end

	assign tick.ready              = tick_ready;
	assign result.valid            = res_valid_q;
	assign result.average_valid    = res_avg_valid_q;
	assign result.average_interval = res_avg_q;
	assign result.event_rate       = res_rate_q;
	assign result.interval_count   = res_cnt_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_ring_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) || (ring_ext < fill_q))
		else $error("ring pointer outside stored entries");

	a_empty_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (sum_q == '0))
		else $error("nonzero sum with empty window");

	a_div_idle_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |-> !div_busy && !div_done)
		else $error("tick taken while a division is running");

endmodule
